FILE: design/yuvrgb_pkg.sv
// shared types and constants for the 4:2:0 block to rgb converter
`default_nettype none
package yuvrgb_pkg;

	localparam int PIX_W  = 8;
	localparam int TERM_W = 18;
	localparam int SUM_W  = 20;
	localparam int LANES  = 4;

	localparam logic signed [TERM_W-1:0] K_Y  = TERM_W'(298);
	localparam logic signed [TERM_W-1:0] K_RV = TERM_W'(409);
	localparam logic signed [TERM_W-1:0] K_GU = TERM_W'(100);
	localparam logic signed [TERM_W-1:0] K_GV = TERM_W'(208);
	localparam logic signed [TERM_W-1:0] K_BU = TERM_W'(516);
	localparam logic signed [8:0]        Y_OFFSET = 9'sd16;
	localparam logic signed [8:0]        C_OFFSET = 9'sd128;
	localparam logic signed [SUM_W-1:0]  ROUND    = SUM_W'(128);

	localparam logic ORDER_UV = 1'b0;
	localparam logic ORDER_VU = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] luma_top_left;
		logic [PIX_W-1:0] luma_top_right;
		logic [PIX_W-1:0] luma_bottom_left;
		logic [PIX_W-1:0] luma_bottom_right;
		logic [PIX_W-1:0] chroma_first;
		logic [PIX_W-1:0] chroma_second;
	} in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_top_left;
		logic [PIX_W-1:0] green_top_left;
		logic [PIX_W-1:0] blue_top_left;
		logic [PIX_W-1:0] red_top_right;
		logic [PIX_W-1:0] green_top_right;
		logic [PIX_W-1:0] blue_top_right;
		logic [PIX_W-1:0] red_bottom_left;
		logic [PIX_W-1:0] green_bottom_left;
		logic [PIX_W-1:0] blue_bottom_left;
		logic [PIX_W-1:0] red_bottom_right;
		logic [PIX_W-1:0] green_bottom_right;
		logic [PIX_W-1:0] blue_bottom_right;
	} out_t;

	// chroma contributions shared by all four lanes
	typedef struct packed {
		logic signed [TERM_W-1:0] red;
		logic signed [TERM_W-1:0] green;
		logic signed [TERM_W-1:0] blue;
	} chroma_terms_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_t;

endpackage
`default_nettype wire

FILE: design/yuvrgb_chroma.sv
// shared chroma stage: order swap, offset removal and constant products
`default_nettype none
module yuvrgb_chroma (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic                          order,
	input  wire logic [yuvrgb_pkg::PIX_W-1:0]  chroma_first,
	input  wire logic [yuvrgb_pkg::PIX_W-1:0]  chroma_second,
	output yuvrgb_pkg::chroma_terms_t          terms_s1
);

	logic [yuvrgb_pkg::PIX_W-1:0]        u;
	logic [yuvrgb_pkg::PIX_W-1:0]        v;
	logic signed [8:0]                   d;
	logic signed [8:0]                   e;
	logic signed [yuvrgb_pkg::TERM_W-1:0] d_ext;
	logic signed [yuvrgb_pkg::TERM_W-1:0] e_ext;
	yuvrgb_pkg::chroma_terms_t           terms;

	always_comb begin
		u = (order == yuvrgb_pkg::ORDER_VU) ? chroma_second : chroma_first;
		v = (order == yuvrgb_pkg::ORDER_VU) ? chroma_first : chroma_second;
		d = $signed({1'b0, u}) - yuvrgb_pkg::C_OFFSET;
		e = $signed({1'b0, v}) - yuvrgb_pkg::C_OFFSET;
		d_ext = yuvrgb_pkg::TERM_W'(d);
		e_ext = yuvrgb_pkg::TERM_W'(e);
		terms.red   = e_ext * yuvrgb_pkg::K_RV;
		terms.green = -(d_ext * yuvrgb_pkg::K_GU) - (e_ext * yuvrgb_pkg::K_GV);
		terms.blue  = d_ext * yuvrgb_pkg::K_BU;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s1 <= terms;
		end
	end

endmodule
`default_nettype wire

FILE: design/yuvrgb_lane.sv
// one pixel lane: luma product, chroma sums, round, shift and clamp
`default_nettype none
module yuvrgb_lane (
	input  wire logic                          clk,
	input  wire logic                          en_s1,
	input  wire logic                          en_s2,
	input  wire logic [yuvrgb_pkg::PIX_W-1:0]  luma,
	input  wire yuvrgb_pkg::chroma_terms_t     terms_s1,
	output yuvrgb_pkg::pix_t                   pix_s2
);

	logic signed [8:0]                    c;
	logic signed [yuvrgb_pkg::TERM_W-1:0] y_prod;
	logic signed [yuvrgb_pkg::TERM_W-1:0] y_prod_s1;
	yuvrgb_pkg::pix_t                     pix;

	function automatic logic [yuvrgb_pkg::PIX_W-1:0] clamp(
		input logic signed [yuvrgb_pkg::TERM_W-1:0] yp,
		input logic signed [yuvrgb_pkg::TERM_W-1:0] term
	);
		logic signed [yuvrgb_pkg::SUM_W-1:0] sum;
		sum = yuvrgb_pkg::SUM_W'(yp) + yuvrgb_pkg::SUM_W'(term) + yuvrgb_pkg::ROUND;
		if (sum[yuvrgb_pkg::SUM_W-1]) begin
			clamp = '0;
		end else if (|sum[yuvrgb_pkg::SUM_W-2:yuvrgb_pkg::PIX_W+8]) begin
			clamp = '1;
		end else begin
			clamp = sum[yuvrgb_pkg::PIX_W+7:8];
		end
	endfunction

	always_comb begin
		c = $signed({1'b0, luma}) - yuvrgb_pkg::Y_OFFSET;
		y_prod = yuvrgb_pkg::TERM_W'(c) * yuvrgb_pkg::K_Y;
		pix.red   = clamp(y_prod_s1, terms_s1.red);
		pix.green = clamp(y_prod_s1, terms_s1.green);
		pix.blue  = clamp(y_prod_s1, terms_s1.blue);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			y_prod_s1 <= y_prod;
		end
		if (en_s2) begin
			pix_s2 <= pix;
		end
	end

endmodule
`default_nettype wire

FILE: design/yuv420_block_to_rgb_unit.sv
// top level: 4:2:0 2x2 block to twelve rgb bytes, four pixel lanes
// an accepted item is registered in stage one and then in stage two, where result valid rises
// throughput: one item per cycle while out_ready does not stall the output, set by the two-stage lane pipeline
// up to two items are held while out_ready is low, then in_ready drops
// arst_n clears the stage valids and the chroma order (u first); data regs are not reset
`default_nettype none
module yuv420_block_to_rgb_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire yuvrgb_pkg::in_t in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output yuvrgb_pkg::out_t out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data
);

	// chroma byte order register
	logic order_q;
	// stage valids
	logic v_s1;
	logic v_s2;
	// stage advance enables
	logic ready_s1;
	logic ready_s2;

	logic [yuvrgb_pkg::LANES-1:0][yuvrgb_pkg::PIX_W-1:0] luma;
	yuvrgb_pkg::chroma_terms_t terms_s1;
	yuvrgb_pkg::pix_t [yuvrgb_pkg::LANES-1:0] pix_s2;

	// config is to be written only while idle; the block does not enforce this, so it is always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= yuvrgb_pkg::ORDER_UV;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= cfg_data;
		end
	end

	// each stage moves when it is empty or its successor moves
	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// lane order follows the result field order
	assign luma[0] = in_data.luma_top_left;
	assign luma[1] = in_data.luma_top_right;
	assign luma[2] = in_data.luma_bottom_left;
	assign luma[3] = in_data.luma_bottom_right;

	// chroma terms computed once, shared by every lane
	yuvrgb_chroma u_chroma (
		.clk           (clk),
		.en            (ready_s1),
		.order         (order_q),
		.chroma_first  (in_data.chroma_first),
		.chroma_second (in_data.chroma_second),
		.terms_s1      (terms_s1)
	);

	for (genvar k = 0; k < yuvrgb_pkg::LANES; k++) begin : g_lane
		yuvrgb_lane u_lane (
			.clk      (clk),
			.en_s1    (ready_s1),
			.en_s2    (ready_s2),
			.luma     (luma[k]),
			.terms_s1 (terms_s1),
			.pix_s2   (pix_s2[k])
		);
	end

	// merge the four lane results into one result item
	assign out_valid = v_s2;
	always_comb begin
		out_data.red_top_left       = pix_s2[0].red;
		out_data.green_top_left     = pix_s2[0].green;
		out_data.blue_top_left      = pix_s2[0].blue;
		out_data.red_top_right      = pix_s2[1].red;
		out_data.green_top_right    = pix_s2[1].green;
		out_data.blue_top_right     = pix_s2[1].blue;
		out_data.red_bottom_left    = pix_s2[2].red;
		out_data.green_bottom_left  = pix_s2[2].green;
		out_data.blue_bottom_left   = pix_s2[2].blue;
		out_data.red_bottom_right   = pix_s2[3].red;
		out_data.green_bottom_right = pix_s2[3].green;
		out_data.blue_bottom_right  = pix_s2[3].blue;
	end

endmodule
`default_nettype wire

FILE: design/yuvrgb_checker.sv
// port-level checks for the block converter and their bind
`default_nettype none
module yuvrgb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire yuvrgb_pkg::out_t out_data
);

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its bytes
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// the block only refuses items when its output is stalled
	a_full_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused with output free");

	// an accepted item reaches the output when out_ready is high while the item sits in stage one
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted item missing at output");

endmodule

bind yuv420_block_to_rgb_unit yuvrgb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
